// File: hdl/rde_pkg.sv
// ---------------------------------------------------------------------------
// rde_pkg - shared definitions for the radix digit emitter
// Widths, radix limits, the digit item type and the character map.
// ---------------------------------------------------------------------------
package rde_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int RADIX_W   = 6;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 7;
	localparam int QBIT_W    = 3;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} rde_digit_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_SEARCH,
		FE_DIV,
		FE_LOAD
	} rde_fstate_t;

	// Register values outside the legal range saturate to the nearest limit.
	function automatic logic [RADIX_W-1:0] rde_radix_sat(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		priority if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Highest quotient bit a digit of this radix can have.
	function automatic logic [QBIT_W-1:0] rde_qmsb(input logic [RADIX_W-1:0] r);
		logic [QBIT_W-1:0] res;
		priority if (r > 6'd32) begin
			res = 3'd5;
		end else if (r > 6'd16) begin
			res = 3'd4;
		end else if (r > 6'd8) begin
			res = 3'd3;
		end else if (r > 6'd4) begin
			res = 3'd2;
		end else if (r > 6'd2) begin
			res = 3'd1;
		end else begin
			res = 3'd0;
		end
		return res;
	endfunction

	// Digits 0 to 9 map to '0'..'9', 10 and up to 'A'..'Z'.
	function automatic logic [CHAR_W-1:0] rde_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < 6'd10) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = CHAR_ALPHA + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

// File: hdl/rde_ram.sv
// ---------------------------------------------------------------------------
// rde_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module rde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/rde_front.sv
// ---------------------------------------------------------------------------
// rde_front - item intake, power search and digit extraction
// Finds the highest power of the radix, keeps the powers in a small RAM and
// extracts one digit at a time by restoring division into the digit queue.
// ---------------------------------------------------------------------------
module rde_front import rde_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [RADIX_W-1:0]     radix,
	output logic                   busy,
	output logic                   push,
	output rde_digit_t             push_data,
	input  logic                   full
);

	localparam int AW = $clog2(VALUE_WIDTH);
	localparam int PW = VALUE_WIDTH + RADIX_W;

	rde_fstate_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] pow_q;
	logic [AW-1:0]          idx_q;
	logic [RADIX_W-1:0]     radix_eff_q;
	logic [QBIT_W-1:0]      qmsb_q;
	logic [QBIT_W-1:0]      bit_q;
	logic [DIGIT_W-1:0]     dig_q;

	logic [PW-1:0]          prod;
	logic [PW-1:0]          shifted;
	logic                   grows;
	logic                   fits;
	logic [DIGIT_W-1:0]     dig_next;
	logic                   step_en;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	assign prod     = PW'(pow_q) * PW'(radix_eff_q);
	assign grows    = prod <= PW'(rem_q);
	assign shifted  = PW'(pow_q) << bit_q;
	assign fits     = PW'(rem_q) >= shifted;
	assign dig_next = dig_q | (DIGIT_W'(fits) << bit_q);
	// The final quotient bit pushes a digit, so it waits for queue room.
	assign step_en  = (bit_q != '0) || !full;
	assign busy     = state_q != FE_IDLE;

	rde_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(VALUE_WIDTH)
	) u_pow_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d         = state_q;
		ram_we          = 1'b0;
		ram_waddr       = idx_q + AW'(1);
		ram_wdata       = prod[VALUE_WIDTH-1:0];
		ram_raddr       = idx_q - AW'(1);
		push            = 1'b0;
		push_data.digit = dig_next;
		push_data.last  = idx_q == '0;
		unique case (state_q)
			FE_IDLE: begin
				if (start) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = VALUE_WIDTH'(1);
					state_d   = FE_SEARCH;
				end
			end
			FE_SEARCH: begin
				if (grows) begin
					ram_we = 1'b1;
				end else begin
					state_d = FE_DIV;
				end
			end
			FE_DIV: begin
				if (step_en && bit_q == '0) begin
					push = 1'b1;
					if (idx_q == '0) begin
						state_d = FE_IDLE;
					end else begin
						state_d = FE_LOAD;
					end
				end
			end
			FE_LOAD: begin
				state_d = FE_DIV;
			end
			default: begin
				state_d = FE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			idx_q   <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				FE_IDLE: begin
					idx_q <= '0;
				end
				FE_SEARCH: begin
					if (grows) begin
						idx_q <= idx_q + AW'(1);
					end else begin
						bit_q <= qmsb_q;
					end
				end
				FE_DIV: begin
					if (step_en) begin
						if (bit_q != '0) begin
							bit_q <= bit_q - QBIT_W'(1);
						end else if (idx_q != '0) begin
							idx_q <= idx_q - AW'(1);
						end
					end
				end
				FE_LOAD: begin
					bit_q <= qmsb_q;
				end
				default: begin
					bit_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FE_IDLE: begin
				if (start) begin
					rem_q       <= value;
					pow_q       <= VALUE_WIDTH'(1);
					radix_eff_q <= rde_radix_sat(radix);
					qmsb_q      <= rde_qmsb(rde_radix_sat(radix));
				end
			end
			FE_SEARCH: begin
				if (grows) begin
					pow_q <= prod[VALUE_WIDTH-1:0];
				end else begin
					dig_q <= '0;
				end
			end
			FE_DIV: begin
				if (step_en) begin
					dig_q <= dig_next;
					if (fits) begin
						rem_q <= rem_q - shifted[VALUE_WIDTH-1:0];
					end
				end
			end
			FE_LOAD: begin
				pow_q <= ram_rdata;
				dig_q <= '0;
			end
			default: begin
				dig_q <= '0;
			end
		endcase
	end

endmodule

// File: hdl/rde_queue.sv
// ---------------------------------------------------------------------------
// rde_queue - short digit queue between front and back
// A small register FIFO of digit items.
// ---------------------------------------------------------------------------
module rde_queue import rde_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rde_digit_t push_data,
	output logic       full,
	input  logic       pop,
	output rde_digit_t pop_data,
	output logic       empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rde_digit_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/rde_back.sv
// ---------------------------------------------------------------------------
// rde_back - character output stage
// Drains one digit a cycle, maps it to ASCII and drives the result strobe.
// ---------------------------------------------------------------------------
module rde_back import rde_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	output logic              pop,
	input  rde_digit_t        pop_data,
	output logic              strobe,
	output logic [CHAR_W-1:0] digit_char,
	output logic              last
);

	logic              strobe_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	// The receiver never stalls, so any queued digit leaves at once.
	assign pop        = !empty;
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			char_q <= rde_char(pop_data.digit);
			last_q <= pop_data.last;
		end
	end

endmodule

// File: hdl/radix_digit_emitter_unit.sv
// ---------------------------------------------------------------------------
// radix_digit_emitter_unit - unsigned value to radix-N ASCII characters
// Converts each value to digits in the configured radix, most significant
// first, one character per strobe, with a flag on the final character.
// ---------------------------------------------------------------------------
// Throughput: the front end takes no new item while busy. Its digit
//   extraction finds one quotient bit per cycle, the final bit of each
//   digit waiting while the queue is full.
// Reset: arst_n clears all control state and sets the radix register to 16.
// ---------------------------------------------------------------------------
module radix_digit_emitter_unit import rde_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   cfg_we,
	input  logic [RADIX_W-1:0]     cfg_wdata,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      digit_char,
	output logic                   last
);

	// The radix register. The front end samples and saturates it when an
	// item is accepted, so a value outside 2 to 36 acts as the nearest limit.
	logic [RADIX_W-1:0] radix_q;

	// Digit items flow from the front end through the queue to the back end.
	rde_digit_t push_data;
	rde_digit_t pop_data;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// The front end accepts an item while idle, searches upward for the
	// highest power of the radix that does not exceed the value, storing
	// every power in its RAM, and then walks the powers back down. Each digit
	// is the quotient of the remainder by the current power, found one bit a
	// cycle by restoring subtraction, the last bit waiting for queue room.
	// A zero value needs no search and gives one zero digit, flagged last.
	rde_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.radix    (radix_q),
		.busy     (busy),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	// The queue lets the front end take the next item while the back end is
	// still sending characters of the previous one.
	rde_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	// The back end registers one character per cycle onto the result ports.
	rde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.strobe    (strobe),
		.digit_char(digit_char),
		.last      (last)
	);

endmodule

// File: hdl/rde_checker.sv
// ---------------------------------------------------------------------------
// rde_checker - port-level assertions for the radix digit emitter
// Checks character range and the start and busy relationship over time.
// ---------------------------------------------------------------------------
module rde_checker import rde_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CHAR_W-1:0] digit_char
);

	// Every emitted character is a decimal digit or an upper-case letter.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
		            (digit_char >= 7'd65 && digit_char <= 7'd90)))
		else $error("character out of range");

	// An accepted item always keeps the unit busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an accepted item");

	// Busy only rises as a result of an accepted item.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

endmodule

bind radix_digit_emitter_unit rde_checker u_rde_checker (.*);

// File: test/tb_radix_digit_emitter_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_radix_digit_emitter_unit - regression for the radix digit emitter
// Sends values to the unit and predicts every ASCII digit and final-character
// flag it should emit for the radix in force. A monitor compares each strobed
// character with the oldest prediction. Directed items cover the radix
// extremes, saturation of the radix register, zero and power boundaries.
// Random phases then run with varied radix settings and random start gaps.
// ---------------------------------------------------------------------------
module tb_radix_digit_emitter_unit;
	import rde_pkg::*;

	// Tail after the unit goes idle: characters may still sit in its output queue.
	localparam int DRAIN_TAIL = 60;
	// Fixed run limit, far above the slowest legal run.
	localparam int RUN_LIMIT_NS = 1000000;
	localparam int PHASE_ITEMS = 42;

	// Digit characters, most significant byte first: digit d sits at byte 35 - d.
	localparam logic [8*36-1:0] DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} char_item_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [VALUE_WIDTH_DEF-1:0] value = '0;
	logic                       cfg_we = 1'b0;
	logic [RADIX_W-1:0]         cfg_wdata = '0;
	logic                       strobe;
	logic [CHAR_W-1:0]          digit_char;
	logic                       last;

	// Characters predicted but not yet seen on the output, oldest first.
	char_item_t         pending_chars[$];
	// Shadow of the radix register as the unit should hold it.
	logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
	int                 mismatch_count = 0;

	radix_digit_emitter_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.strobe     (strobe),
		.digit_char (digit_char),
		.last       (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The register accepts any 6-bit code; codes below two act as binary and
	// codes above thirty-six act as base thirty-six.
	function automatic logic [63:0] effective_base(input logic [RADIX_W-1:0] r);
		logic [63:0] b;
		b = 64'(r);
		if (b < 64'd2) begin
			b = 64'd2;
		end else if (b > 64'd36) begin
			b = 64'd36;
		end
		return b;
	endfunction

	// Works out the whole character string for one value and appends it to
	// the pending queue. The power search uses a division test so that the
	// power never runs past the value, and zero yields a single '0'.
	task automatic queue_expected_chars(input logic [VALUE_WIDTH_DEF-1:0] v);
		logic [63:0] rem;
		logic [63:0] pw;
		logic [63:0] base;
		logic [63:0] d;
		char_item_t  item;
		int          n;
		bit          done;
		base = effective_base(radix_shadow);
		rem = 64'(v);
		pw = 64'd1;
		while (rem / pw >= base) begin
			pw = pw * base;
		end
		n = 0;
		done = 1'b0;
		while (!done) begin
			d = rem / pw;
			rem = rem % pw;
			item.ch = DIGIT_SET[8 * (35 - int'(d % 64'd36)) +: CHAR_W];
			item.fin = (pw == 64'd1);
			pending_chars.push_back(item);
			n++;
			if (pw == 64'd1 || n >= VALUE_WIDTH_DEF) begin
				done = 1'b1;
			end else begin
				pw = pw / base;
			end
		end
	endtask

	// Offers one item after an idle gap and holds start until the unit takes
	// it. Start is left high on return, so a follow-on item with no gap keeps
	// it high without a drop in between.
	task automatic send_value(input logic [VALUE_WIDTH_DEF-1:0] v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do begin
			@(posedge clk);
		end while (busy);
		queue_expected_chars(v);
	endtask

	// Drops start and waits until the unit is idle and every predicted
	// character has come out, plus a tail for anything still in flight.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Radix writes happen only while the unit is idle.
	task automatic set_radix(input logic [RADIX_W-1:0] r);
		cfg_wdata <= r;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_shadow = r;
	endtask

	// Random value with a spread of magnitudes: full range, shortened, tiny,
	// near a power of the base, and the two ends of the range.
	function automatic logic [VALUE_WIDTH_DEF-1:0] pick_value(input logic [63:0] base);
		logic [VALUE_WIDTH_DEF-1:0] v;
		logic [63:0]                pw;
		int                         kind;
		int                         k;
		int                         i;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				v = $urandom;
			end
			4, 5: begin
				v = $urandom >> $urandom_range(0, 31);
			end
			6: begin
				v = $urandom_range(0, 40);
			end
			7: begin
				pw = 64'd1;
				k = $urandom_range(1, 31);
				for (i = 0; i < k && pw * base <= 64'hFFFF_FFFF; i++) begin
					pw = pw * base;
				end
				v = VALUE_WIDTH_DEF'(pw + 64'($urandom_range(0, 2)) - 64'd1);
			end
			default: begin
				v = ($urandom_range(0, 1) != 0) ? '1 : '0;
			end
		endcase
		return v;
	endfunction

	// Every strobe is one character; the receiver has no way to hold it off,
	// so it is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		char_item_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected character: expected none, actual char %0d last %0b",
					$time, digit_char, last);
			end else begin
				want = pending_chars.pop_front();
				if (digit_char !== want.ch) begin
					mismatch_count++;
					$display("%0t: digit_char mismatch: expected %0d, actual %0d",
						$time, want.ch, digit_char);
				end
				if (last !== want.fin) begin
					mismatch_count++;
					$display("%0t: last mismatch: expected %0b, actual %0b",
						$time, want.fin, last);
				end
			end
		end
	end

	// Base sixteen from reset, with no write: zero, one, the edges of the
	// first two digits and the all-ones value.
	task automatic test_default_radix();
		send_value(32'd0, $urandom_range(0, 14));
		send_value(32'd1, $urandom_range(0, 14));
		send_value(32'd15, $urandom_range(0, 14));
		send_value(32'd16, 0);
		send_value(32'hFFFF_FFFF, $urandom_range(0, 14));
		wait_idle();
	endtask

	// Register codes at and beyond both limits. Code zero and code one must
	// behave as binary, which also gives the longest strings of 32 digits.
	task automatic test_radix_limits();
		set_radix(6'd0);
		send_value(32'hFFFF_FFFF, 0);
		wait_idle();
		set_radix(6'd1);
		send_value(32'h8000_0000, $urandom_range(0, 14));
		wait_idle();
		set_radix(6'd2);
		send_value(32'd1, 0);
		send_value(32'h5555_5555, 0);
		wait_idle();
		set_radix(6'd63);
		send_value(32'hFFFF_FFFF, $urandom_range(0, 14));
		wait_idle();
		set_radix(6'd37);
		send_value(32'd35, 0);
		wait_idle();
		set_radix(6'd36);
		send_value(32'd36, $urandom_range(0, 14));
		send_value(32'd1295, 0);
		wait_idle();
	endtask

	// Values on either side of a power of the base, including the largest
	// power of three that fits in 32 bits.
	task automatic test_power_edges();
		set_radix(6'd10);
		send_value(32'd999_999_999, 0);
		send_value(32'd1_000_000_000, $urandom_range(0, 14));
		send_value(32'hFFFF_FFFF, 0);
		wait_idle();
		set_radix(6'd3);
		send_value(32'd3_486_784_400, $urandom_range(0, 14));
		send_value(32'd3_486_784_401, 0);
		wait_idle();
		set_radix(6'd7);
		send_value(32'd0, 0);
		wait_idle();
	endtask

	// Random phases, each with its own radix code. The first two sit on the
	// saturating ends of the register; some phases run with no start gaps.
	task automatic test_random_values();
		logic [63:0] base;
		bit          quiet;
		int          phase;
		int          i;
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_radix(RADIX_W'($urandom_range(0, 2)));
				1: set_radix(RADIX_W'($urandom_range(36, 63)));
				default: set_radix(RADIX_W'($urandom_range(0, 63)));
			endcase
			base = effective_base(radix_shadow);
			quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				send_value(pick_value(base), quiet ? 0 : $urandom_range(0, 14));
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_default_radix();
		test_radix_limits();
		test_power_edges();
		test_random_values();
		// Anything still predicted here was never emitted.
		if (pending_chars.size() != 0) begin
			mismatch_count++;
			$display("%0t: missing characters: expected %0d more, actual 0",
				$time, pending_chars.size());
		end
		if (mismatch_count == 0) begin
			$display("radix_digit_emitter_unit regression: pass");
		end else begin
			$display("radix_digit_emitter_unit regression: fail");
		end
		$finish;
	end

	// A hung handshake or a unit that never drains ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("radix_digit_emitter_unit regression: fail");
		$finish;
	end

endmodule

// File: files.f
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/rde_front.sv
hdl/rde_queue.sv
hdl/rde_back.sv
hdl/radix_digit_emitter_unit.sv
hdl/rde_checker.sv
test/tb_radix_digit_emitter_unit.sv
